// ===== src/pab_pkg.sv =====
// ============================================================================
// pab_pkg
// Shared constants, types and coefficient lookup for the additive partial bank.
// ============================================================================
package pab_pkg;

  // Default bank size and sine resolution.
  localparam int unsigned MaxPartialsDef = 16;
  localparam int unsigned SineDepthDef   = 1024;

  // Iterative divider geometry.
  localparam int unsigned DivW    = 24;
  localparam int unsigned DivCntW = 5;

  // Configuration register indexes.
  localparam logic [1:0] RegActiveCount  = 2'd0;
  localparam logic [1:0] RegHighDamping  = 2'd1;
  localparam logic [1:0] RegBrightTarget = 2'd2;
  localparam logic [1:0] RegBrightSmooth = 2'd3;

  // Odd polynomial for sin(pi/2 * v), Q1.30.
  localparam logic [30:0] SinC1 = 31'd1686629714;
  localparam logic [30:0] SinC3 = 31'd693598668;
  localparam logic [30:0] SinC5 = 31'd85569306;
  localparam logic [30:0] SinC7 = 31'd5026995;
  localparam logic [30:0] SinC9 = 31'd172273;

  // Request to the shared divider.
  typedef struct packed {
    logic               start;
    logic [DivW-1:0]    rem_init;
    logic [DivW-1:0]    num;
    logic [DivW-1:0]    den;
    logic [DivCntW-1:0] n_bits;
  } div_req_t;

  // Coefficient for each Horner step, highest order first after C9.
  function automatic logic [30:0] horner_coef(input logic [1:0] sel);
    logic [30:0] c;
    case (sel)
      2'd0:    c = SinC7;
      2'd1:    c = SinC5;
      2'd2:    c = SinC3;
      default: c = SinC1;
    endcase
    return c;
  endfunction

endpackage

// ===== src/pab_div.sv =====
// ============================================================================
// pab_div
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
// ============================================================================
module pab_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pab_pkg::div_req_t           req_i,
  output logic                        done_o,
  output logic [pab_pkg::DivW-1:0]    quot_o
);
  import pab_pkg::*;

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DivW-1:0]    rem_q;
  logic [DivW-1:0]    num_q;
  logic [DivW-1:0]    den_q;
  logic [DivW-1:0]    quot_q;
  logic [DivW:0]      trial;
  logic               fits;

  // Bring down the next numerator bit and try to subtract the divisor.
  assign trial = {rem_q, num_q[DivW-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DivCntW'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.n_bits;
      end else if (busy_q) begin
        cnt_q <= cnt_q - DivCntW'(1);
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.rem_init;
      num_q  <= req_i.num;
      den_q  <= req_i.den;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? DivW'(trial - {1'b0, den_q}) : trial[DivW-1:0];
      num_q  <= {num_q[DivW-2:0], 1'b0};
      quot_q <= {quot_q[DivW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== src/additive_partial_bank_top.sv =====
// ============================================================================
// additive_partial_bank_top
// Additive synthesis bank of decaying sine partials with brightness rolloff.
// ============================================================================
//
//  Channel   Direction  Handshake                       Payload
//  -------   ---------  ------------------------------  ---------------------------------
//  in        in         in_valid_i / in_ready_o         op, partial_index, phase_step,
//                                                       start_level, decay_factor, pitch_mult
//  sample    out        sample_valid_o / sample_ready_i sample (signed Q4.19)
//  cfg       in         cfg_we_i (no wait)              cfg_idx_i, cfg_wdata_i
//
// A load item writes one row of the partial memory as it is taken.
// A tick item glides the cutoff, renders each active partial in turn and
// then outputs the sample. A partial's rolloff needs a division only when
// its step lies above the cutoff, while its damping always needs one; the
// shared one-bit-per-cycle divider works out both.
// Reset empties the partial memory at once through per-row valid bits, so no
// clearing pass is needed. While a tick is in progress the input is not ready;
// a finished sample waits in the output register and a new item is accepted
// meanwhile, but a second tick holds at its end until the first is taken.
//
module additive_partial_bank_top #(
  parameter int unsigned MAX_PARTIALS     = pab_pkg::MaxPartialsDef,
  parameter int unsigned SINE_TABLE_DEPTH = pab_pkg::SineDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [23:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic [3:0]         partial_index_i,
  input  logic [23:0]        phase_step_i,
  input  logic [15:0]        start_level_i,
  input  logic [15:0]        decay_factor_i,
  input  logic [15:0]        pitch_mult_i,
  output logic               sample_valid_o,
  input  logic               sample_ready_i,
  output logic signed [23:0] sample_o
);
  import pab_pkg::*;

  localparam int unsigned KW = (MAX_PARTIALS > 1) ? $clog2(MAX_PARTIALS) : 1;
  localparam int unsigned CW = $clog2(MAX_PARTIALS + 1);
  localparam int unsigned LW = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned AW = 33 + $clog2(MAX_PARTIALS);
  localparam int unsigned RW = 80;

  // Sequencer states.
  localparam logic [4:0] StIdle  = 5'd0;
  localparam logic [4:0] StCutM  = 5'd1;
  localparam logic [4:0] StCutA  = 5'd2;
  localparam logic [4:0] StRd    = 5'd3;
  localparam logic [4:0] StV2M   = 5'd4;
  localparam logic [4:0] StV2A   = 5'd5;
  localparam logic [4:0] StHM    = 5'd6;
  localparam logic [4:0] StHA    = 5'd7;
  localparam logic [4:0] StSM    = 5'd8;
  localparam logic [4:0] StSA    = 5'd9;
  localparam logic [4:0] StRoll  = 5'd10;
  localparam logic [4:0] StRollW = 5'd11;
  localparam logic [4:0] StDmpM  = 5'd12;
  localparam logic [4:0] StDmpS  = 5'd13;
  localparam logic [4:0] StDmpW  = 5'd14;
  localparam logic [4:0] StT1M   = 5'd15;
  localparam logic [4:0] StT2M   = 5'd16;
  localparam logic [4:0] StT3M   = 5'd17;
  localparam logic [4:0] StTA    = 5'd18;
  localparam logic [4:0] StPhA   = 5'd19;
  localparam logic [4:0] StWb    = 5'd20;
  localparam logic [4:0] StOut   = 5'd21;

  logic [4:0]  state_q, state_d;

  // Configuration and glide state.
  logic [4:0]  act_cnt_q;
  logic [15:0] hi_damp_q;
  logic [23:0] tgt_q;
  logic [15:0] smooth_q;
  logic [23:0] cutoff_q;

  // Per-tick working registers.
  logic [15:0]          pm_q;
  logic [CW-1:0]        cnt_q;
  logic [CW-1:0]        k_q;
  logic [63:0]          p_q;
  logic [30:0]          v2_q;
  logic [31:0]          t_q;
  logic [1:0]           hcnt_q;
  logic [14:0]          sm_q;
  logic                 neg_q;
  logic [16:0]          roll_q;
  logic [16:0]          damp_q;
  logic [23:0]          phase_new_q;
  logic signed [AW-1:0] sum_q;
  logic                 svalid_q;
  logic [23:0]          sample_q;

  // Partial memory: {phase, step, level, decay} per row.
  logic [RW-1:0]           mem_q [MAX_PARTIALS];
  logic [MAX_PARTIALS-1:0] vld_q;
  logic [RW-1:0]           row_q;
  logic                    row_vld_q;
  logic [RW-1:0]           row;
  logic [23:0]             r_phase, r_step;
  logic [15:0]             r_level, r_decay;
  logic                    mem_we;
  logic [KW-1:0]           mem_wa;
  logic [RW-1:0]           mem_wd;

  logic        in_acc;
  logic        cut_dn;
  logic [23:0] dmag;
  logic [23:0] adj;
  logic [CW-1:0] cnt_sat;
  logic [CW-1:0] denom;
  logic [31:0] mul_a, mul_b;
  logic [LW-1:0] idx;
  logic [1:0]  quad;
  logic [30:0] u, v;
  logic [16:0] mrnd;
  logic [14:0] msat;
  logic [31:0] term;
  div_req_t    div_req;
  logic        div_done;
  logic [DivW-1:0] div_quot;
  logic [AW-1:0] omag;
  logic [AW-12:0] orsh;
  logic [23:0] omag_sat;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;

  // Current partial's row; a row never written reads as zero.
  assign row     = row_vld_q ? row_q : '0;
  assign r_phase = row[79:56];
  assign r_step  = row[55:32];
  assign r_level = row[31:16];
  assign r_decay = row[15:0];

  // Cutoff glide towards the target.
  assign cut_dn = (tgt_q < cutoff_q);
  assign dmag   = cut_dn ? (cutoff_q - tgt_q) : (tgt_q - cutoff_q);
  assign adj    = 24'(p_q[40:16] + 25'(p_q[15]));

  assign cnt_sat = (32'(act_cnt_q) > MAX_PARTIALS) ? CW'(MAX_PARTIALS) : CW'(act_cnt_q);
  assign denom   = (cnt_q > CW'(1)) ? (cnt_q - CW'(1)) : CW'(1);

  // Phase to quarter-wave argument: quadrant and position within it (Q0.30).
  assign idx  = r_phase[23 -: LW];
  assign quad = idx[LW-1 -: 2];
  assign u    = 31'(idx[LW-3:0]) << (32 - LW);
  assign v    = quad[0] ? (31'h4000_0000 - u) : u;

  // Rounding of the quarter sine to Q1.15, capped just below one.
  assign mrnd = 17'((p_q[63:30] + 34'd16384) >> 15);
  assign msat = (mrnd > 17'd32767) ? 15'd32767 : mrnd[14:0];

  assign term = p_q[47:16];

  // Shared multiplier operand selection; the product is always registered.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      StCutM: begin
        mul_a = 32'(dmag);
        mul_b = 32'(17'h10000 - 17'(smooth_q));
      end
      StV2M: begin
        mul_a = 32'(v);
        mul_b = 32'(v);
      end
      StHM: begin
        mul_a = 32'(v2_q);
        mul_b = t_q;
      end
      StSM: begin
        mul_a = 32'(v);
        mul_b = t_q;
      end
      StDmpM: begin
        mul_a = 32'(17'h10000 - 17'(hi_damp_q));
        mul_b = 32'(k_q);
      end
      StT1M: begin
        mul_a = 32'(sm_q);
        mul_b = 32'(r_level);
      end
      StT2M: begin
        mul_a = p_q[31:0];
        mul_b = 32'(roll_q);
      end
      StT3M: begin
        mul_a = p_q[47:16];
        mul_b = 32'(damp_q);
      end
      StTA: begin
        mul_a = 32'(r_step);
        mul_b = 32'(pm_q);
      end
      StPhA: begin
        mul_a = 32'(r_level);
        mul_b = 32'(r_decay);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
  end

  // Divider requests: rolloff in state StRoll, damping in state StDmpS.
  always_comb begin
    div_req = '0;
    if (state_q == StRoll && r_step > cutoff_q) begin
      div_req.start    = 1'b1;
      div_req.rem_init = cutoff_q;
      div_req.num      = '0;
      div_req.den      = r_step;
      div_req.n_bits   = DivCntW'(16);
    end else if (state_q == StDmpS) begin
      div_req.start    = 1'b1;
      div_req.rem_init = '0;
      div_req.num      = p_q[23:0];
      div_req.den      = DivW'(denom);
      div_req.n_bits   = DivCntW'(24);
    end
  end

  pab_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_acc && op_i) state_d = StCutM;
      StCutM:  state_d = StCutA;
      StCutA:  state_d = (cnt_sat == '0) ? StOut : StRd;
      StRd:    state_d = StV2M;
      StV2M:   state_d = StV2A;
      StV2A:   state_d = StHM;
      StHM:    state_d = StHA;
      StHA:    state_d = (hcnt_q == 2'd3) ? StSM : StHM;
      StSM:    state_d = StSA;
      StSA:    state_d = StRoll;
      StRoll:  state_d = (r_step > cutoff_q) ? StRollW : StDmpM;
      StRollW: if (div_done) state_d = StDmpM;
      StDmpM:  state_d = StDmpS;
      StDmpS:  state_d = StDmpW;
      StDmpW:  if (div_done) state_d = StT1M;
      StT1M:   state_d = StT2M;
      StT2M:   state_d = StT3M;
      StT3M:   state_d = StTA;
      StTA:    state_d = StPhA;
      StPhA:   state_d = StWb;
      StWb:    state_d = ((k_q + CW'(1)) == cnt_q) ? StOut : StRd;
      StOut:   if (!svalid_q || sample_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Output rounding and saturation of the accumulated sum.
  assign omag     = sum_q[AW-1] ? AW'(-sum_q) : AW'(sum_q);
  assign orsh     = (AW-11)'((({1'b0, omag}) + (AW+1)'(2048)) >> 12);
  always_comb begin
    if (sum_q[AW-1]) begin
      omag_sat = (orsh > (AW-11)'(8388608)) ? 24'd8388608 : orsh[23:0];
    end else begin
      omag_sat = (orsh > (AW-11)'(8388607)) ? 24'd8388607 : orsh[23:0];
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      act_cnt_q <= 5'd1;
      hi_damp_q <= 16'hFFFF;
      tgt_q     <= 24'd8388608;
      smooth_q  <= 16'd0;
      cutoff_q  <= 24'd8388608;
      cnt_q     <= '0;
      k_q       <= '0;
      hcnt_q    <= '0;
      svalid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegActiveCount:  act_cnt_q <= cfg_wdata_i[4:0];
          RegHighDamping:  hi_damp_q <= cfg_wdata_i[15:0];
          RegBrightTarget: tgt_q     <= cfg_wdata_i;
          RegBrightSmooth: smooth_q  <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if (state_q == StCutA) begin
        cutoff_q <= cut_dn ? (cutoff_q - adj) : (cutoff_q + adj);
        cnt_q    <= cnt_sat;
        k_q      <= '0;
      end
      if (state_q == StV2A) hcnt_q <= '0;
      if (state_q == StHA)  hcnt_q <= hcnt_q + 2'd1;
      if (state_q == StWb)  k_q <= k_q + CW'(1);
      if (svalid_q && sample_ready_i) svalid_q <= 1'b0;
      if (state_q == StOut && (!svalid_q || sample_ready_i)) svalid_q <= 1'b1;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_acc && op_i) pm_q <= pitch_mult_i;
    case (state_q)
      StCutA:  sum_q <= '0;
      StV2A: begin
        v2_q <= p_q[60:30];
        t_q  <= 32'(SinC9);
      end
      StHA:    t_q <= 32'(horner_coef(hcnt_q)) - p_q[61:30];
      StSA: begin
        sm_q  <= msat;
        neg_q <= quad[1];
      end
      StRoll:  roll_q <= 17'h10000;
      StRollW: if (div_done) roll_q <= 17'(div_quot[15:0]);
      StDmpW:  if (div_done) damp_q <= 17'h10000 - div_quot[16:0];
      StTA:    sum_q <= neg_q ? (sum_q - AW'(term)) : (sum_q + AW'(term));
      StPhA:   phase_new_q <= r_phase + p_q[37:14];
      StOut:   if (!svalid_q || sample_ready_i) begin
        sample_q <= sum_q[AW-1] ? (~omag_sat + 24'd1) : omag_sat;
      end
      default: ;
    endcase
  end

  // Partial memory: one write port, one registered read port at the current partial.
  assign mem_we = (in_acc && !op_i && (32'(partial_index_i) < MAX_PARTIALS))
                  || (state_q == StWb);
  assign mem_wa = (state_q == StWb) ? k_q[KW-1:0] : KW'(partial_index_i);
  assign mem_wd = (state_q == StWb)
                  ? {phase_new_q, r_step, p_q[31:16], r_decay}
                  : {24'd0, phase_step_i, start_level_i, decay_factor_i};

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    row_q <= mem_q[k_q[KW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      row_vld_q <= 1'b0;
    end else begin
      if (mem_we) vld_q[mem_wa] <= 1'b1;
      row_vld_q <= vld_q[k_q[KW-1:0]];
    end
  end

  assign sample_valid_o = svalid_q;
  assign sample_o       = signed'(sample_q);

endmodule

// ===== src/pab_chk.sv =====
// ============================================================================
// pab_chk
// Port-level checks on the additive partial bank, bound to the top level.
// ============================================================================
module pab_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        op_i,
  input logic        sample_valid_o,
  input logic        sample_ready_i,
  input logic [23:0] sample_o
);

  // A waiting sample stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_o && !sample_ready_i |=> sample_valid_o)
    else $error("sample dropped before it was taken");

  // A waiting sample keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_o && !sample_ready_i |=> $stable(sample_o))
    else $error("sample changed while stalled");

  // A tick occupies the block for at least the following cycle.
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && op_i |=> !in_ready_o)
    else $error("input ready straight after a tick");

  // A load never produces a sample.
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !op_i && !sample_valid_o |=> !sample_valid_o)
    else $error("sample appeared after a load");

  // A sample only appears at the end of a tick's processing.
  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sample_valid_o) |-> $past(!in_ready_o))
    else $error("sample appeared while idle");

endmodule

bind additive_partial_bank_top pab_chk u_pab_chk (.*);

// ===== dv/additive_partial_bank_top_test.sv =====
// ============================================================================
// additive_partial_bank_top_test
// Self-checking testbench for the additive partial bank. Load and tick items
// are driven with random gaps, the sample output is stalled at random, and a
// bit-exact predictor of the partial bank checks every sample in order.
// ============================================================================
module additive_partial_bank_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pab_pkg::*;

  localparam int unsigned Partials = 16;
  localparam logic        OpLoad   = 1'b0;
  localparam logic        OpTick   = 1'b1;
  localparam longint      CycleLimit = 8000000;

  // Bit-exact prediction of the bank plus the queue of samples still due.
  class partial_bank_scoreboard;
    logic [4:0]  active_count;
    logic [15:0] high_damping;
    logic [23:0] bright_target;
    logic [15:0] bright_smooth;
    logic [23:0] cutoff_now;
    logic [23:0] phase_acc [Partials];
    logic [23:0] step_val  [Partials];
    logic [15:0] level_val [Partials];
    logic [15:0] decay_val [Partials];
    logic [23:0] expected_samples [$];
    int unsigned mismatches;

    function new();
      active_count  = 5'd1;
      high_damping  = 16'hFFFF;
      bright_target = 24'd8388608;
      bright_smooth = 16'd0;
      cutoff_now    = 24'd8388608;
      mismatches    = 0;
      for (int k = 0; k < Partials; k++) begin
        phase_acc[k] = '0;
        step_val[k]  = '0;
        level_val[k] = '0;
        decay_val[k] = '0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [23:0] data);
      case (idx)
        RegActiveCount:  active_count  = data[4:0];
        RegHighDamping:  high_damping  = data[15:0];
        RegBrightTarget: bright_target = data;
        default:         bright_smooth = data[15:0];
      endcase
    endfunction

    // Signed Q1.15 sine of a Q0.24 phase, by odd polynomial per quadrant.
    function int phase_sine(logic [23:0] phase);
      longint unsigned idx, quad, rem_q, u, v, v2, t, m;
      idx   = phase >> 14;
      quad  = (idx * 4) / 1024;
      rem_q = (idx * 4) - quad * 1024;
      u     = (rem_q << 30) / 1024;
      v     = quad[0] ? ((64'd1 << 30) - u) : u;
      v2    = (v * v) >> 30;
      t     = 64'(SinC9);
      t     = 64'(SinC7) - ((v2 * t) >> 30);
      t     = 64'(SinC5) - ((v2 * t) >> 30);
      t     = 64'(SinC3) - ((v2 * t) >> 30);
      t     = 64'(SinC1) - ((v2 * t) >> 30);
      m     = (((v * t) >> 30) + 16384) >> 15;
      if (m > 32767) m = 32767;
      return quad[1] ? -int'(m) : int'(m);
    endfunction

    // Glide the cutoff, sum the active partials and advance them.
    function logic [23:0] render_tick(logic [15:0] pitch);
      longint unsigned kf, adj, cnt, denom, sm, roll, damp, term, mag;
      longint          sum;
      int              s;
      kf = 65536 - longint'(bright_smooth);
      if (bright_target >= cutoff_now) begin
        adj = (longint'(bright_target - cutoff_now) * kf + 32768) >> 16;
        cutoff_now = cutoff_now + adj[23:0];
      end else begin
        adj = (longint'(cutoff_now - bright_target) * kf + 32768) >> 16;
        cutoff_now = cutoff_now - adj[23:0];
      end
      cnt   = (active_count > Partials) ? Partials : active_count;
      denom = (cnt > 1) ? cnt - 1 : 1;
      sum   = 0;
      for (int k = 0; k < cnt; k++) begin
        s    = phase_sine(phase_acc[k]);
        sm   = (s < 0) ? -s : s;
        roll = 65536;
        damp = 65536 - ((65536 - longint'(high_damping)) * k) / denom;
        if (step_val[k] > cutoff_now)
          roll = (longint'(cutoff_now) << 16) / step_val[k];
        term = sm * level_val[k];
        term = (term * roll) >> 16;
        term = (term * damp) >> 16;
        sum  = (s < 0) ? sum - longint'(term) : sum + longint'(term);
        phase_acc[k] = 24'(longint'(phase_acc[k]) +
                           ((longint'(step_val[k]) * pitch) >> 14));
        level_val[k] = 16'((longint'(level_val[k]) * decay_val[k]) >> 16);
      end
      mag = (sum < 0) ? -sum : sum;
      mag = (mag + 2048) >> 12;
      if (sum < 0) begin
        if (mag > 8388608) mag = 8388608;
        return 24'(-longint'(mag));
      end
      if (mag > 8388607) mag = 8388607;
      return 24'(mag);
    endfunction

    function void note_item(logic op, logic [3:0] idx, logic [23:0] step,
                            logic [15:0] level, logic [15:0] decay,
                            logic [15:0] pitch);
      if (op == OpLoad) begin
        step_val[idx]  = step;
        level_val[idx] = level;
        decay_val[idx] = decay;
        phase_acc[idx] = '0;
      end else begin
        expected_samples.push_back(render_tick(pitch));
      end
    endfunction

    function void check_sample(logic [23:0] actual);
      logic [23:0] want;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected sample %0d", $signed(actual));
        return;
      end
      want = expected_samples.pop_front();
      if (want !== actual) begin
        mismatches++;
        if (mismatches <= 10)
          $display("sample mismatch: expected %0d, got %0d", $signed(want),
                   $signed(actual));
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [23:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        op_i = OpLoad;
  logic [3:0]  partial_index_i = '0;
  logic [23:0] phase_step_i = '0;
  logic [15:0] start_level_i = '0;
  logic [15:0] decay_factor_i = '0;
  logic [15:0] pitch_mult_i = '0;
  logic        sample_valid_o;
  logic        sample_ready_i = 1'b0;
  logic signed [23:0] sample_o;

  partial_bank_scoreboard bank_sb = new();
  longint      cycle_count = 0;
  int unsigned items_taken = 0;
  bit          burst_mode = 1'b0;

  additive_partial_bank_top uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .op_i, .partial_index_i, .phase_step_i,
    .start_level_i, .decay_factor_i, .pitch_mult_i,
    .sample_valid_o, .sample_ready_i, .sample_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // A run that outlives every plausible slow path is a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Sample side. Ready is mostly high, drops at random, and once, after a few
  // hundred items, stays low for a long stretch so that a finished sample sits
  // in the output register and the next tick backs up into the input.
  int unsigned hold_cycles = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (sample_valid_o && sample_ready_i) bank_sb.check_sample(sample_o);
    if (!hold_done && items_taken >= 300) begin
      hold_done   <= 1'b1;
      hold_cycles <= 4000;
      sample_ready_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      sample_ready_i <= 1'b0;
    end else if (burst_mode) begin
      sample_ready_i <= 1'b1;
    end else begin
      sample_ready_i <= ($urandom_range(0, 99) < 65) ||
                        ($urandom_range(0, 99) < 2 && 1'b0);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Offers one item, waits for the edge where it is taken, then pauses for a
  // random gap, which may be zero. The caller is always sitting on a rising edge when this starts.
  task automatic send_item(logic op, logic [3:0] idx, logic [23:0] step,
                           logic [15:0] level, logic [15:0] decay,
                           logic [15:0] pitch);
    int unsigned gap;
    in_valid_i      <= 1'b1;
    op_i            <= op;
    partial_index_i <= idx;
    phase_step_i    <= step;
    start_level_i   <= level;
    decay_factor_i  <= decay;
    pitch_mult_i    <= pitch;
    do @(posedge clk_i); while (!in_ready_o);
    bank_sb.note_item(op, idx, step, level, decay, pitch);
    items_taken++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    bank_sb.write_reg(idx, data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits for every sample still owed, then lets a trailing load settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (bank_sb.expected_samples.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Step sizes lean towards the audible range, but whole-width values appear
  // so that wrapping and rolloff are both exercised.
  function automatic logic [23:0] pick_step();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return 24'($urandom_range(0, 400000));
    if (r < 8) return 24'($urandom_range(0, 8388608));
    return 24'($urandom);
  endfunction

  initial begin
    logic [4:0]  counts [6];
    int unsigned phase_items;
    logic        op;

    counts = '{5'd0, 5'd1, 5'd2, 5'd16, 5'd31, 5'd4};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: a bank of extreme partials, then ticks at the corners of
    // the pitch multiplier with full damping range and a low cutoff.
    write_reg(RegActiveCount, 24'd16);
    write_reg(RegHighDamping, 24'd0);
    write_reg(RegBrightTarget, 24'd100000);
    write_reg(RegBrightSmooth, 24'd0);
    send_item(OpTick, 4'd0, 24'd0, 16'd0, 16'd0, 16'd16384);
    send_item(OpLoad, 4'd0, 24'd0, 16'hFFFF, 16'hFFFF, 16'd0);
    send_item(OpLoad, 4'd1, 24'd8388608, 16'hFFFF, 16'd0, 16'd0);
    send_item(OpLoad, 4'd15, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(OpLoad, 4'd2, 24'd100000, 16'hFFFF, 16'hF000, 16'd0);
    send_item(OpLoad, 4'd3, 24'd262144, 16'h8000, 16'hFFFF, 16'd0);
    send_item(OpLoad, 4'd7, 24'd4194304, 16'hFFFF, 16'hFFFF, 16'd0);
    send_item(OpTick, 4'd0, 24'd0, 16'd0, 16'd0, 16'd0);
    send_item(OpTick, 4'd0, 24'd0, 16'd0, 16'd0, 16'hFFFF);
    send_item(OpTick, 4'hF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'd16384);
    send_item(OpTick, 4'd0, 24'd0, 16'd0, 16'd0, 16'd16384);
    send_item(OpTick, 4'd0, 24'd0, 16'd0, 16'd0, 16'd32768);
    send_item(OpTick, 4'd0, 24'd0, 16'd0, 16'd0, 16'd1);
    wait_idle();

    // Random phases, each with its own register setting. The first phases
    // visit the extremes; count zero and counts above the bank size are among
    // them. Small counts dominate to keep ticks short.
    for (int ph = 0; ph < 14; ph++) begin
      wait_idle();
      if (ph < 6) begin
        write_reg(RegActiveCount, 24'(counts[ph]));
        write_reg(RegHighDamping, (ph % 2) ? 24'hFFFF : 24'd0);
        write_reg(RegBrightTarget, (ph % 3 == 0) ? 24'd0 : 24'd8388608);
        write_reg(RegBrightSmooth, (ph % 2) ? 24'd0 : 24'hFFFF);
      end else begin
        write_reg(RegActiveCount, 24'($urandom_range(1, 8)));
        write_reg(RegHighDamping, 24'($urandom_range(0, 65535)));
        write_reg(RegBrightTarget, 24'($urandom_range(0, 8388608)));
        write_reg(RegBrightSmooth, 24'($urandom_range(0, 65535)));
      end
      burst_mode  = ($urandom_range(0, 3) == 0);
      phase_items = 138;
      for (int i = 0; i < phase_items; i++) begin
        op = ($urandom_range(0, 99) < 55) ? OpTick : OpLoad;
        send_item(op, 4'($urandom), pick_step(), 16'($urandom),
                  ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                  16'($urandom_range(60000, 65535)), 16'($urandom));
      end
    end
    burst_mode = 1'b0;

    wait_idle();
    repeat (200) @(posedge clk_i);
    if (bank_sb.mismatches == 0 && bank_sb.expected_samples.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/pab_pkg.sv
src/pab_div.sv
src/additive_partial_bank_top.sv
src/pab_chk.sv
dv/additive_partial_bank_top_test.sv
